### rtl/deq_pkg.sv
package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int COUNT_W   = 5;

	localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_BACK   = 2'd2;
	localparam logic [1:0] OP_POP_FRONT  = 2'd3;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef logic signed [WORD_W-1:0] word_t;

endpackage

### rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words held in a ring buffer of DEPTH
// entries (one synchronous RAM, one write and two read addresses). Each input
// word is one operation: push back, push front, pop back or pop front. For
// every operation exactly one result word follows, giving the front and back
// entries afterwards (all ones, i.e. minus one, when the queue is empty), the
// entry count (low five bits) and an overflow flag that is set when a push
// met a full queue and was dropped. A pop on an empty queue changes nothing.
// One operation at a time: the accepting edge updates the pointers and writes
// the RAM, the read state then fetches front and back through the registered
// RAM read port, and the show state presents the result until it is taken.
// in_stall stays high from acceptance until the result word has been taken.
// The RAM needs no clearing after reset.
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic signed [deq_pkg::WORD_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [deq_pkg::WORD_W-1:0] front_word,
	output logic signed [deq_pkg::WORD_W-1:0] back_word,
	output logic [deq_pkg::COUNT_W-1:0]   count,
	output logic                          overflow
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic          overflow_q;

	// entry storage, no reset: an unwritten entry is read only when the queue is empty, and the output masks it
	deq_pkg::word_t mem_q [DEPTH];
	deq_pkg::word_t rd_front_q;
	deq_pkg::word_t rd_back_q;

	logic          in_take;
	logic          out_take;
	logic          is_push;
	logic          full;
	logic          empty;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail_pos;
	logic [AW:0]   back_sum;
	logic [AW-1:0] back_pos;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] head_nxt;
	logic [CW-1:0] cnt_nxt;
	logic [CW+4:0] cnt_ext;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign is_push = (func == deq_pkg::OP_PUSH_BACK) || (func == deq_pkg::OP_PUSH_FRONT);
	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);

	// wrap pointers by hand so that any DEPTH works, not only powers of two
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// free slot behind the back entry: head + count, below 2*DEPTH
	assign tail_sum = (AW+1)'(head_q) + (AW+1)'(cnt_q);
	assign tail_pos = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
	                                               : AW'(tail_sum);

	// back entry: head + count - 1, taken as head when empty
	assign back_sum = empty ? (AW+1)'(head_q) : tail_sum - (AW+1)'(1);
	assign back_pos = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
	                                               : AW'(back_sum);

	// decode the operation into a pointer move, a count step and a RAM write
	always_comb begin
		head_nxt = head_q;
		cnt_nxt  = cnt_q;
		wr_en    = 1'b0;
		wr_addr  = tail_pos;
		unique case (func)
			deq_pkg::OP_PUSH_BACK: begin
				if (!full) begin
					wr_en   = 1'b1;
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				if (!full) begin
					wr_en    = 1'b1;
					wr_addr  = head_dec;
					head_nxt = head_dec;
					cnt_nxt  = cnt_q + CW'(1);
				end
			end
			deq_pkg::OP_POP_BACK: begin
				if (!empty) begin
					cnt_nxt = cnt_q - CW'(1);
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (!empty) begin
					head_nxt = head_inc;
					cnt_nxt  = cnt_q - CW'(1);
				end
			end
			default: begin
				head_nxt = head_q;
			end
		endcase
	end

	// sequencer and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			cnt_q      <= '0;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						head_q     <= head_nxt;
						cnt_q      <= cnt_nxt;
						overflow_q <= is_push && full;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// write port: store the pushed word on the accepting edge
	always_ff @(posedge clk) begin
		if (in_take && wr_en) begin
			mem_q[wr_addr] <= value;
		end
	end

	// read ports: fetch front and back in the read state, hold while shown
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_front_q <= mem_q[head_q];
			rd_back_q  <= mem_q[back_pos];
		end
	end

	assign cnt_ext = {5'b0, cnt_q};

	assign out_valid  = (state_q == ST_SHOW);
	assign front_word = empty ? deq_pkg::EMPTY_WORD : rd_front_q;
	assign back_word  = empty ? deq_pkg::EMPTY_WORD : rd_back_q;
	assign count      = cnt_ext[deq_pkg::COUNT_W-1:0];
	assign overflow   = overflow_q;

	// the count never runs past the buffer size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	// the head pointer stays inside the buffer
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(DEPTH - 1))
		else $error("head pointer out of range");

	// a dropped push is only ever reported against a full queue
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> full)
		else $error("overflow reported while not full");

	// an accepted word always starts the RAM read
	a_take_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_READ) && !out_valid)
		else $error("accepted word did not start a read");

endmodule

### bench/deq_monitor.sv
module deq_monitor #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   func,
	input  deq_pkg::word_t               value,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  deq_pkg::word_t               front_word,
	input  deq_pkg::word_t               back_word,
	input  logic [deq_pkg::COUNT_W-1:0]  count,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           outstanding
);

	typedef struct packed {
		deq_pkg::word_t              front;
		deq_pkg::word_t              back;
		logic [deq_pkg::COUNT_W-1:0] cnt;
		logic                        ovf;
	} deq_status_t;

	// shadow ring buffer
	deq_pkg::word_t ring [DEPTH];
	int             head;
	int             held;
	deq_status_t    status_due [$];
	deq_status_t    due;

	// Apply one operation to the shadow ring and return the status word it yields.
	function automatic deq_status_t apply_op(input logic [1:0] op, input deq_pkg::word_t word);
		deq_status_t st;
		st.ovf = 1'b0;
		if (op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT) begin
			if (held >= DEPTH) begin
				st.ovf = 1'b1;
			end else if (op == deq_pkg::OP_PUSH_BACK) begin
				held++;
				ring[(head + held - 1) % DEPTH] = word;
			end else begin
				head = (head + DEPTH - 1) % DEPTH;
				ring[head] = word;
				held++;
			end
		end else if (held != 0) begin
			if (op == deq_pkg::OP_POP_FRONT)
				head = (head + 1) % DEPTH;
			held--;
		end
		if (held == 0) begin
			st.front = deq_pkg::EMPTY_WORD;
			st.back  = deq_pkg::EMPTY_WORD;
		end else begin
			st.front = ring[head];
			st.back  = ring[(head + held - 1) % DEPTH];
		end
		st.cnt = held[deq_pkg::COUNT_W-1:0];
		return st;
	endfunction

	// Compare the outgoing word first: it can never belong to a word taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head        = 0;
			held        = 0;
			fail_count  = 0;
			outstanding = 0;
			status_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: front %0d back %0d count %0d overflow %0b",
							front_word, back_word, count, overflow);
				end else begin
					due = status_due[0];
					status_due.delete(0);
					if (front_word !== due.front || back_word !== due.back ||
							count !== due.cnt || overflow !== due.ovf) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: front %0d/%0d back %0d/%0d count %0d/%0d ovf %0b/%0b",
								due.front, front_word, due.back, back_word,
								due.cnt, count, due.ovf, overflow);
					end
				end
			end
			if (in_valid && !in_stall)
				status_due.insert(status_due.size(), apply_op(func, value));
			outstanding = status_due.size();
		end
	end

endmodule

### bench/double_ended_queue_test.sv
module double_ended_queue_test;

	// Nothing may move on either channel for this many cycles before the run is called hung:
	// well above the longest sender gap plus pipeline plus receiver stall.
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 440;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic [1:0]                  func      = deq_pkg::OP_PUSH_BACK;
	deq_pkg::word_t              value     = '0;
	logic                        out_stall = 1'b0;
	logic                        in_stall;
	logic                        out_valid;
	deq_pkg::word_t              front_word;
	deq_pkg::word_t              back_word;
	logic [deq_pkg::COUNT_W-1:0] count;
	logic                        overflow;

	int fail_count;
	int outstanding;
	int send_idle   = 0;   // percent of cycles the sender holds back
	int recv_stall  = 0;   // percent of cycles the receiver stalls
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	double_ended_queue #(
		.DEPTH(deq_pkg::DEPTH_DEF)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.front_word (front_word),
		.back_word  (back_word),
		.count      (count),
		.overflow   (overflow)
	);

	deq_monitor #(
		.DEPTH(deq_pkg::DEPTH_DEF)
	) i_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_word  (front_word),
		.back_word   (back_word),
		.count       (count),
		.overflow    (overflow),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Receiver back-pressure: redraw the stall at every falling edge.
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_stall);
	end

	// Watchdog: count cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offer one operation word and hold it until the block takes it. Idle gaps are
	// drawn first; valid is lowered only in a step where it is not raised again.
	task automatic send_op(input logic [1:0] op, input deq_pkg::word_t word);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		value    <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every predicted status word has come back.
	task automatic drain_wait();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Push or pop, with the push share steering the queue towards full or empty.
	function automatic logic [1:0] pick_op(input int push_pct);
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
		return $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
	endfunction

	// Mostly random words, with the signed extremes, zero and minus one mixed in.
	// Minus one matters: a held minus one must not be taken for an empty queue.
	function automatic deq_pkg::word_t pick_word();
		case ($urandom_range(7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return deq_pkg::word_t'($urandom);
		endcase
	endfunction

	initial begin
		int             push_pct;
		deq_pkg::word_t bit_word;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: pops on an empty queue, both extremes at both ends, back to empty.
		send_op(deq_pkg::OP_POP_BACK, 32'sh7fff_ffff);
		send_op(deq_pkg::OP_POP_FRONT, 32'sh8000_0000);
		send_op(deq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
		send_op(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
		send_op(deq_pkg::OP_POP_BACK, '0);
		send_op(deq_pkg::OP_POP_FRONT, '0);
		// Fill to the brim from both ends with walking-bit words, then overflow at each end.
		for (int i = 0; i < deq_pkg::DEPTH_DEF; i++) begin
			bit_word = 32'sd1 <<< (2 * i);
			send_op(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
				i[0] ? ~bit_word : bit_word);
		end
		send_op(deq_pkg::OP_PUSH_BACK, -32'sd1);
		send_op(deq_pkg::OP_PUSH_FRONT, 32'sh5a5a_a5a5);
		drain_wait();

		// Random phases: no idling, sender idle, receiver stalling, both.
		// Between phases the sender pauses until every status word is home.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle = 0;  recv_stall = 0;  end
				1:       begin send_idle = 74; recv_stall = 0;  end
				2:       begin send_idle = 0;  recv_stall = 74; end
				default: begin send_idle = 19; recv_stall = 19; end
			endcase
			push_pct = 50;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// Re-bias now and then so the queue swings between full and empty.
				if (i % 40 == 0) begin
					case ($urandom_range(4))
						0:       push_pct = 10;
						1:       push_pct = 40;
						2:       push_pct = 55;
						3:       push_pct = 85;
						default: push_pct = 97;
					endcase
				end
				send_op(pick_op(push_pct), pick_word());
			end
			drain_wait();
		end

		// Let the pipeline settle so a stray word would still be caught.
		send_idle  = 0;
		recv_stall = 0;
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
